[hw/rtl/ppe_pkg.sv]
// Shared constants, codes and record types of the particle pool engine.
package ppe_pkg;

  localparam int POOL_SIZE = 64;
  localparam int SLOT_W    = 6;
  localparam int COUNT_W   = 7;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_EMIT = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_INACTIVE = 2'd2;

  // One particle as it is kept in the slot memory.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [15:0]        life_left;
    logic [15:0]        life_max;
    logic [15:0]        size;
    logic [23:0]        rgb;
    logic [7:0]         alpha;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Clamp a widened sum back into the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [37:0] hi;
    logic signed [37:0] lo;
    hi = 38'sh0_7FFF_FFFF;
    lo = -38'sh0_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

[hw/rtl/particle_pool_engine_top.sv]
// Top level of the particle pool engine: command sequencer around the slot memory.
//
// A pool of 64 particles lives in one slot memory, with the active flags and
// the live count in flip-flops. Every request gives one result. A read of an
// inactive slot goes straight to the response state; a read of an active one
// first waits for the registered memory data. An emit scans the active flags
// one slot per cycle from slot 0 and takes the lowest free slot, or reports
// the pool full. A tick visits all 64 slots in turn: an inactive slot is
// skipped, a slot whose life runs out is freed, and a surviving one goes
// through memory read, three parallel 32x17 multiplies, add and saturate, an
// eight-step alpha divider and write back. A new request is taken once the
// previous one is finished; its result may still sit in the output register.
module particle_pool_engine_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_cmd,
  input  logic [15:0]         in_dt,
  input  logic [5:0]          in_slot,
  input  logic signed [31:0]  in_pos_x,
  input  logic signed [31:0]  in_pos_y,
  input  logic signed [31:0]  in_pos_z,
  input  logic signed [31:0]  in_vel_x,
  input  logic signed [31:0]  in_vel_y,
  input  logic signed [31:0]  in_vel_z,
  input  logic [15:0]         in_life,
  input  logic [15:0]         in_size,
  input  logic [31:0]         in_rgba,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [5:0]          out_slot_used,
  output logic                out_alive,
  output logic signed [31:0]  out_out_x,
  output logic signed [31:0]  out_out_y,
  output logic signed [31:0]  out_out_z,
  output logic [23:0]         out_out_rgb,
  output logic [7:0]          out_out_alpha,
  output logic [15:0]         out_out_size,
  output logic [6:0]          out_live_count
);
  import ppe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RDATA, S_EMIT, S_TRD, S_TMUL, S_TADD, S_TDIV, S_TWR, S_RESP
  } state_t;

  state_t               state_r;
  logic [POOL_SIZE-1:0] active_r;
  logic [COUNT_W-1:0]   live_r;
  logic [SLOT_W-1:0]    idx_r;
  logic [15:0]          dt_r;
  rec_t                 em_r;
  rec_t                 rec_r;
  logic signed [48:0]   prod_x_r, prod_y_r, prod_z_r;
  logic [23:0]          rem_r;
  logic [2:0]           k_r;
  logic [7:0]           quot_r;

  // Pending result, moved to the output register in S_RESP.
  logic [1:0]           res_status_r;
  logic [SLOT_W-1:0]    res_slot_r;
  logic                 res_alive_r;
  rec_t                 res_rec_r;

  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_alive_r;
  logic signed [31:0]   out_x_r, out_y_r, out_z_r;
  logic [23:0]          out_rgb_r;
  logic [7:0]           out_alpha_r;
  logic [15:0]          out_size_r;
  logic [COUNT_W-1:0]   out_live_r;

  logic                 ram_we, ram_re;
  logic [SLOT_W-1:0]    ram_waddr, ram_raddr;
  rec_t                 ram_wdata, ram_rdata;

  logic                 in_acc;
  logic                 last_idx;
  logic                 out_free;
  logic signed [36:0]   step_x, step_y, step_z;
  logic [23:0]          div_cand;
  logic [15:0]          life_new;
  rec_t                 tick_rec;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign last_idx = (idx_r == SLOT_W'(POOL_SIZE - 1));
  assign out_free = !out_valid_r || out_ready;
  assign step_x   = prod_x_r[48:12];
  assign step_y   = prod_y_r[48:12];
  assign step_z   = prod_z_r[48:12];
  assign div_cand = {8'd0, rec_r.life_max} << k_r;
  assign life_new = ram_rdata.life_left - dt_r;

  always_comb begin
    tick_rec           = ram_rdata;
    tick_rec.life_left = life_new;
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = rec_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_cmd == CMD_READ && active_r[in_slot]) begin
          ram_re    = 1'b1;
          ram_raddr = in_slot;
        end
      end
      S_TRD: ram_re = active_r[idx_r];
      S_EMIT: begin
        ram_we    = !active_r[idx_r];
        ram_wdata = em_r;
      end
      S_TWR: ram_we = 1'b1;
      default: ;
    endcase
  end

  ppe_ram #(.WIDTH(REC_W), .DEPTH(POOL_SIZE)) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_RESP the output register is refilled whenever it is free.
      if (out_valid_r && out_ready && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            dt_r         <= in_dt;
            idx_r        <= '0;
            res_alive_r  <= 1'b0;
            res_rec_r    <= '0;
            em_r.pos_x     <= in_pos_x;
            em_r.pos_y     <= in_pos_y;
            em_r.pos_z     <= in_pos_z;
            em_r.vel_x     <= in_vel_x;
            em_r.vel_y     <= in_vel_y;
            em_r.vel_z     <= in_vel_z;
            em_r.life_left <= in_life;
            em_r.life_max  <= in_life;
            em_r.size      <= in_size;
            em_r.rgb       <= in_rgba[31:8];
            em_r.alpha     <= in_rgba[7:0];
            case (in_cmd)
              CMD_TICK: begin
                res_status_r <= ST_OK;
                res_slot_r   <= '0;
                state_r      <= S_TRD;
              end
              CMD_EMIT: begin
                res_status_r <= ST_OK;
                res_slot_r   <= '0;
                state_r      <= S_EMIT;
              end
              CMD_READ: begin
                res_slot_r <= in_slot;
                if (active_r[in_slot]) begin
                  res_status_r <= ST_OK;
                  state_r      <= S_RDATA;
                end else begin
                  res_status_r <= ST_INACTIVE;
                  state_r      <= S_RESP;
                end
              end
              default: begin
                res_status_r <= ST_OK;
                res_slot_r   <= '0;
                state_r      <= S_RESP;
              end
            endcase
          end
        end
        S_RDATA: begin
          res_alive_r <= 1'b1;
          res_rec_r   <= ram_rdata;
          state_r     <= S_RESP;
        end
        S_EMIT: begin
          if (!active_r[idx_r]) begin
            active_r[idx_r] <= 1'b1;
            live_r          <= live_r + COUNT_W'(1);
            res_slot_r      <= idx_r;
            state_r         <= S_RESP;
          end else if (last_idx) begin
            res_status_r <= ST_FULL;
            state_r      <= S_RESP;
          end else begin
            idx_r <= idx_r + SLOT_W'(1);
          end
        end
        S_TRD: begin
          if (active_r[idx_r]) begin
            state_r <= S_TMUL;
          end else if (last_idx) begin
            state_r <= S_RESP;
          end else begin
            idx_r <= idx_r + SLOT_W'(1);
          end
        end
        S_TMUL: begin
          if (ram_rdata.life_left <= dt_r) begin
            // Life used up: the slot is freed and its record left as is.
            active_r[idx_r] <= 1'b0;
            live_r          <= live_r - COUNT_W'(1);
            if (last_idx) begin
              state_r <= S_RESP;
            end else begin
              idx_r   <= idx_r + SLOT_W'(1);
              state_r <= S_TRD;
            end
          end else begin
            rec_r    <= tick_rec;
            prod_x_r <= ram_rdata.vel_x * $signed({1'b0, dt_r});
            prod_y_r <= ram_rdata.vel_y * $signed({1'b0, dt_r});
            prod_z_r <= ram_rdata.vel_z * $signed({1'b0, dt_r});
            state_r  <= S_TADD;
          end
        end
        S_TADD: begin
          // The arithmetic shift of the product rounds toward minus infinity.
          rec_r.pos_x <= sat32(38'(rec_r.pos_x) + 38'(step_x));
          rec_r.pos_y <= sat32(38'(rec_r.pos_y) + 38'(step_y));
          rec_r.pos_z <= sat32(38'(rec_r.pos_z) + 38'(step_z));
          rem_r   <= ({8'd0, rec_r.life_left} << 8) - {8'd0, rec_r.life_left};
          k_r     <= 3'd7;
          quot_r  <= '0;
          state_r <= S_TDIV;
        end
        S_TDIV: begin
          // Restoring division; life_left never exceeds life_max, so eight
          // quotient bits are enough.
          if (rem_r >= div_cand) begin
            rem_r     <= rem_r - div_cand;
            quot_r[k_r] <= 1'b1;
            if (k_r == 3'd0) begin
              rec_r.alpha <= quot_r | 8'd1;
            end
          end else if (k_r == 3'd0) begin
            rec_r.alpha <= quot_r;
          end
          if (k_r == 3'd0) begin
            state_r <= S_TWR;
          end else begin
            k_r <= k_r - 3'd1;
          end
        end
        S_TWR: begin
          if (last_idx) begin
            state_r <= S_RESP;
          end else begin
            idx_r   <= idx_r + SLOT_W'(1);
            state_r <= S_TRD;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_slot_r   <= res_slot_r;
            out_alive_r  <= res_alive_r;
            out_x_r      <= res_rec_r.pos_x;
            out_y_r      <= res_rec_r.pos_y;
            out_z_r      <= res_rec_r.pos_z;
            out_rgb_r    <= res_rec_r.rgb;
            out_alpha_r  <= res_rec_r.alpha;
            out_size_r   <= res_rec_r.size;
            out_live_r   <= live_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_used  = out_slot_r;
  assign out_alive      = out_alive_r;
  assign out_out_x      = out_x_r;
  assign out_out_y      = out_y_r;
  assign out_out_z      = out_z_r;
  assign out_out_rgb    = out_rgb_r;
  assign out_out_alpha  = out_alpha_r;
  assign out_out_size   = out_size_r;
  assign out_live_count = out_live_r;

`ifndef ASSERT_OFF
  a_live_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    live_r == COUNT_W'($countones(active_r)))
    else $error("live count disagrees with active flags");

  a_write_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_EMIT || state_r == S_TWR))
    else $error("slot memory written outside emit or write back");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> out_live_r == COUNT_W'(POOL_SIZE))
    else $error("pool full reported with a free slot");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("request accepted but sequencer stayed idle");
`endif

endmodule

[hw/rtl/ppe_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module ppe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[tb/tb_particle_pool_engine_top.sv]
// Self-checking testbench for the particle pool engine: emit, tick, read and no-op requests.
`timescale 1ns / 100ps

module tb_particle_pool_engine_top;
  import ppe_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;

  typedef struct {
    logic [1:0]         cmd;
    logic [15:0]        dt;
    logic [5:0]         slot;
    logic signed [31:0] px, py, pz, vx, vy, vz;
    logic [15:0]        life;
    logic [15:0]        size;
    logic [31:0]        rgba;
  } request_t;

  typedef struct {
    logic [1:0]         status;
    logic [5:0]         slot_used;
    logic               alive;
    logic signed [31:0] x, y, z;
    logic [23:0]        rgb;
    logic [7:0]         alpha;
    logic [15:0]        size;
    logic [6:0]         live;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_cmd = '0;
  logic [15:0] in_dt = '0;
  logic [5:0] in_slot = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [31:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic [15:0] in_life = '0, in_size = '0;
  logic [31:0] in_rgba = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [5:0] out_slot_used;
  logic out_alive;
  logic signed [31:0] out_out_x, out_out_y, out_out_z;
  logic [23:0] out_out_rgb;
  logic [7:0] out_out_alpha;
  logic [15:0] out_out_size;
  logic [6:0] out_live_count;

  particle_pool_engine_top dut (.*);

  always #5 clk = ~clk;

  // Predictor state for the pool.
  logic               pool_active [POOL_SIZE];
  logic signed [31:0] pool_pos [POOL_SIZE][3];
  logic signed [31:0] pool_vel [POOL_SIZE][3];
  logic [15:0]        pool_life [POOL_SIZE];
  logic [15:0]        pool_life_max [POOL_SIZE];
  logic [15:0]        pool_size [POOL_SIZE];
  logic [23:0]        pool_rgb [POOL_SIZE];
  logic [7:0]         pool_alpha [POOL_SIZE];

  request_t pending_requests[$];
  result_t  expected_results[$];
  int       mismatch_count = 0;
  bit       stimulus_done = 1'b0;

  // Position step: velocity * dt, shifted right 12 with floor, then saturated.
  function automatic logic signed [31:0] move_axis(logic signed [31:0] pos,
                                                   logic signed [31:0] vel,
                                                   logic [15:0] dt);
    longint prod, sum;
    prod = longint'(vel) * longint'({1'b0, dt});
    sum = longint'(pos) + (prod >>> 12);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  function automatic int live_particles();
    int n = 0;
    for (int i = 0; i < POOL_SIZE; i++) if (pool_active[i]) n++;
    return n;
  endfunction

  function automatic int lowest_free_slot();
    for (int i = 0; i < POOL_SIZE; i++) if (!pool_active[i]) return i;
    return -1;
  endfunction

  function automatic result_t apply_request(request_t r);
    result_t res;
    int found;
    res = '{default: '0};
    case (r.cmd)
      CMD_TICK: begin
        for (int i = 0; i < POOL_SIZE; i++) begin
          if (!pool_active[i]) continue;
          if (pool_life[i] <= r.dt) begin
            pool_active[i] = 1'b0;
            continue;
          end
          pool_life[i] = pool_life[i] - r.dt;
          for (int a = 0; a < 3; a++)
            pool_pos[i][a] = move_axis(pool_pos[i][a], pool_vel[i][a], r.dt);
          if (pool_life_max[i] != 0)
            pool_alpha[i] = 8'((32'(pool_life[i]) * 255) / pool_life_max[i]);
        end
      end
      CMD_EMIT: begin
        found = lowest_free_slot();
        if (found < 0) begin
          res.status = ST_FULL;
        end else begin
          pool_active[found] = 1'b1;
          pool_pos[found][0] = r.px; pool_pos[found][1] = r.py; pool_pos[found][2] = r.pz;
          pool_vel[found][0] = r.vx; pool_vel[found][1] = r.vy; pool_vel[found][2] = r.vz;
          pool_life[found] = r.life;
          pool_life_max[found] = r.life;
          pool_size[found] = r.size;
          pool_rgb[found] = r.rgba[31:8];
          pool_alpha[found] = r.rgba[7:0];
          res.slot_used = 6'(found);
        end
      end
      CMD_READ: begin
        res.slot_used = r.slot;
        if (pool_active[r.slot]) begin
          res.alive = 1'b1;
          res.x = pool_pos[r.slot][0];
          res.y = pool_pos[r.slot][1];
          res.z = pool_pos[r.slot][2];
          res.rgb = pool_rgb[r.slot];
          res.alpha = pool_alpha[r.slot];
          res.size = pool_size[r.slot];
        end else begin
          res.status = ST_INACTIVE;
        end
      end
      default: ;
    endcase
    res.live = 7'(live_particles());
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_request(request_t r);
    pending_requests = {pending_requests, r};
  endtask

  function automatic request_t random_emit();
    request_t r;
    r.cmd = CMD_EMIT;
    r.dt = 16'($urandom);
    r.slot = 6'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        r.px = 32'sh7FFF_0000; r.py = 32'sh8000_0000; r.pz = $urandom;
      end
      default: begin
        r.px = $urandom; r.py = $urandom; r.pz = $urandom;
      end
    endcase
    if ($urandom_range(0, 1)) begin
      r.vx = $urandom; r.vy = $urandom; r.vz = $urandom;
    end else begin
      r.vx = $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh0002_0000;
      r.vy = $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh0002_0000;
      r.vz = $urandom;
    end
    r.life = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 16'h2000));
    r.size = 16'($urandom);
    r.rgba = $urandom;
    return r;
  endfunction

  function automatic request_t make_request(logic [1:0] cmd, logic [15:0] dt,
                                            logic [5:0] slot);
    request_t r;
    r = random_emit();
    r.cmd = cmd;
    r.dt = dt;
    r.slot = slot;
    return r;
  endfunction

  // Stimulus: the predictor runs over the whole queue before reset is released, since requests are taken in order.
  initial begin
    request_t r;
    int pick;
    for (int i = 0; i < POOL_SIZE; i++) pool_active[i] = 1'b0;

    queue_request(make_request(CMD_READ, 16'd0, 6'd63));
    queue_request(make_request(CMD_TICK, 16'hFFFF, 6'd0));
    queue_request(make_request(CMD_NOP, 16'hFFFF, 6'h3F));
    r = make_request(CMD_EMIT, 16'd0, 6'd0);
    r.px = 32'sh7FFF_FFFF; r.py = 32'sh8000_0000; r.pz = 0;
    r.vx = 32'sh7FFF_FFFF; r.vy = 32'sh8000_0000; r.vz = -1;
    r.life = 16'hFFFF; r.size = 16'hFFFF; r.rgba = 32'hFFFF_FFFF;
    queue_request(r);
    r.px = 0; r.py = 0; r.vx = -1; r.vy = 1; r.life = 16'd1; r.size = 0; r.rgba = 0;
    queue_request(r);
    r.life = 16'd0;
    queue_request(r);
    queue_request(make_request(CMD_READ, 16'd0, 6'd0));
    queue_request(make_request(CMD_READ, 16'd0, 6'd2));
    queue_request(make_request(CMD_TICK, 16'd1, 6'd0));
    queue_request(make_request(CMD_READ, 16'd0, 6'd0));
    queue_request(make_request(CMD_READ, 16'd0, 6'd1));
    queue_request(make_request(CMD_TICK, 16'hFFFF, 6'd0));
    queue_request(make_request(CMD_READ, 16'd0, 6'd0));
    // Fill the pool, then one more emit hits the full case.
    for (int i = 0; i < POOL_SIZE + 1; i++) begin
      r = random_emit();
      r.life = 16'hFFFF;
      queue_request(r);
    end
    queue_request(make_request(CMD_READ, 16'd0, 6'd63));
    queue_request(make_request(CMD_TICK, 16'h0800, 6'd0));
    queue_request(make_request(CMD_READ, 16'd0, 6'd17));
    queue_request(make_request(CMD_TICK, 16'hFFFF, 6'd0));

    for (int n = 0; n < 320; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) r = random_emit();
      else if (pick < 55)
        r = make_request(CMD_TICK, ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(0, 16'h0400)),
                         6'($urandom));
      else if (pick < 95) r = make_request(CMD_READ, 16'($urandom), 6'($urandom));
      else r = make_request(CMD_NOP, 16'($urandom), 6'($urandom));
      queue_request(r);
    end

    foreach (pending_requests[i])
      expected_results = {expected_results, apply_request(pending_requests[i])};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Acceptance is seen at the rising edge; the driver moves on only after it.
  bit in_taken = 1'b0;
  always @(posedge clk) in_taken <= in_valid && in_ready;

  task automatic r_drive(request_t r);
    in_valid <= 1'b1;
    in_cmd <= r.cmd; in_dt <= r.dt; in_slot <= r.slot;
    in_pos_x <= r.px; in_pos_y <= r.py; in_pos_z <= r.pz;
    in_vel_x <= r.vx; in_vel_y <= r.vy; in_vel_z <= r.vz;
    in_life <= r.life; in_size <= r.size; in_rgba <= r.rgba;
  endtask

  // Driver: presents each request after a random gap, holds it until taken.
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // The request is still waiting to be taken.
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_requests.size() > 0) begin
      r_drive(pending_requests.pop_front());
      send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    end else begin
      in_valid <= 1'b0;
      stimulus_done <= 1'b1;
    end
  end

  // Receiver stall pattern: after each taken result, out_ready drops for a random stall, sometimes none.
  bit out_taken = 1'b0;
  always @(posedge clk) out_taken <= out_valid && out_ready;

  int stall_left = 0;
  always @(negedge clk) begin
    int wait_cycles;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (out_taken) begin
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      stall_left <= wait_cycles;
      out_ready <= (wait_cycles == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_status), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_slot_used !== want.slot_used)
          report_mismatch("slot_used", out_slot_used, want.slot_used);
        if (out_alive !== want.alive) report_mismatch("alive", out_alive, want.alive);
        if (out_out_x !== want.x) report_mismatch("out_x", out_out_x, want.x);
        if (out_out_y !== want.y) report_mismatch("out_y", out_out_y, want.y);
        if (out_out_z !== want.z) report_mismatch("out_z", out_out_z, want.z);
        if (out_out_rgb !== want.rgb) report_mismatch("out_rgb", out_out_rgb, want.rgb);
        if (out_out_alpha !== want.alpha)
          report_mismatch("out_alpha", out_out_alpha, want.alpha);
        if (out_out_size !== want.size) report_mismatch("out_size", out_out_size, want.size);
        if (out_live_count !== want.live)
          report_mismatch("live_count", out_live_count, want.live);
      end
    end
  end

  initial begin
    wait (stimulus_done && expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_particle_pool_engine_top: PASS");
    end else begin
      $display("tb_particle_pool_engine_top: FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("tb_particle_pool_engine_top: FAIL");
    $finish;
  end

endmodule
